### rtl/core/lbf_pkg.sv
// ----------------------------------------------------------------------------
// lbf_pkg: shared constants of the D1Q3 fractional flow lattice
// Register indexes, request kinds and fixed port widths.
// ----------------------------------------------------------------------------
package lbf_pkg;

   localparam int CSR_ADDR_BITS = 1;
   localparam int CSR_DATA_BITS = 9;

   localparam logic [CSR_ADDR_BITS-1:0] REG_ACTIVE_CELLS = 1'd0;
   localparam logic [CSR_ADDR_BITS-1:0] REG_SPEED_SHIFT  = 1'd1;

   localparam logic FUNC_STEP = 1'b0;
   localparam logic FUNC_READ = 1'b1;

   localparam int ACTIVE_BITS = 9;
   localparam int SHIFT_BITS  = 4;
   localparam int CELL_BITS   = 8;

endpackage

### rtl/core/lbf_ram.sv
// ----------------------------------------------------------------------------
// lbf_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lbf_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

### rtl/core/lbf_div_cell.sv
// ----------------------------------------------------------------------------
// lbf_div_cell: one restoring division cell
// Produces one quotient bit and hands the shifted remainder to the next cell.
// ----------------------------------------------------------------------------
module lbf_div_cell #(
   parameter int W = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                vld_in,
   input  logic [W-1:0]        rem_in,
   input  logic [W-1:0]        den_in,
   input  logic [W-1:0]        quo_in,
   input  logic signed [W-1:0] sval_in,
   input  logic                zero_in,
   output logic                vld_out,
   output logic [W-1:0]        rem_out,
   output logic [W-1:0]        den_out,
   output logic [W-1:0]        quo_out,
   output logic signed [W-1:0] sval_out,
   output logic                zero_out
);

   logic       vld_ff;
   logic [W-1:0] rem_ff, rem_in_w, den_ff, quo_ff;
   logic signed [W-1:0] sval_ff;
   logic       zero_ff, take;

   // The remainder stays below the divisor, so the doubled value fits.
   always_comb begin
      take     = (rem_in >= den_in);
      rem_in_w = take ? ((rem_in - den_in) << 1) : (rem_in << 1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
      rem_ff  <= rem_in_w;
      den_ff  <= den_in;
      quo_ff  <= {quo_in[W-2:0], take};
      sval_ff <= sval_in;
      zero_ff <= zero_in;
   end

   assign vld_out  = vld_ff;
   assign rem_out  = rem_ff;
   assign den_out  = den_ff;
   assign quo_out  = quo_ff;
   assign sval_out = sval_ff;
   assign zero_out = zero_ff;

endmodule

### rtl/core/lbf_collide.sv
// ----------------------------------------------------------------------------
// lbf_collide: collision pipeline for one cell per cycle
// Squares, a row of division cells for the fractional flux, and equilibria.
// ----------------------------------------------------------------------------
module lbf_collide
   import lbf_pkg::*;
#(
   parameter int W = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [SHIFT_BITS-1:0] speed_shift,
   input  logic                  in_vld,
   input  logic signed [W-1:0]   in_sat,
   output logic                  out_vld,
   output logic signed [W-1:0]   out_rest,
   output logic signed [W-1:0]   out_right,
   output logic signed [W-1:0]   out_left
);

   localparam int F = W - 2;
   localparam int NCELL = F + 1;
   localparam logic [63:0] ONE64 = 64'd1 << F;
   localparam logic signed [W-1:0] W_REST = W'((4 * ONE64 + 64'd3) / 64'd6);
   localparam logic signed [W-1:0] W_MOVE = W'((ONE64 + 64'd3) / 64'd6);
   localparam logic signed [W+1:0] ONE_E = (W+2)'(1) << F;
   localparam logic signed [W+1:0] MAX_E = {3'b000, {(W-1){1'b1}}};
   localparam logic signed [W+1:0] MIN_E = {3'b111, {(W-1){1'b0}}};
   localparam logic signed [2*W-1:0] MAX_P = {{(W+1){1'b0}}, {(W-1){1'b1}}};
   localparam logic signed [2*W-1:0] MIN_P = {{(W+1){1'b1}}, {(W-1){1'b0}}};
   localparam logic signed [2*W-1:0] BIAS_P = {{(2*W-F){1'b0}}, {F{1'b1}}};

   function automatic logic signed [W-1:0] sat_e(input logic signed [W+1:0] x);
      logic signed [W+1:0] y;
      y = x;
      if (x > MAX_E) y = MAX_E;
      if (x < MIN_E) y = MIN_E;
      return y[W-1:0];
   endfunction

   // Product truncated toward zero and saturated.
   function automatic logic signed [W-1:0] mul_q(input logic signed [W-1:0] a,
                                                 input logic signed [W-1:0] b);
      logic signed [2*W-1:0] p, sh;
      p = (2*W)'(a) * (2*W)'(b);
      if (p[2*W-1]) p = p + BIAS_P;
      sh = p >>> F;
      if (sh > MAX_P) sh = MAX_P;
      if (sh < MIN_P) sh = MIN_P;
      return sh[W-1:0];
   endfunction

   logic                vld1_ff, vld2_ff, vld3_ff, vld4_ff, vld5_ff;
   logic signed [W-1:0] s1_ff, sq1_ff, om1_ff;
   logic signed [W-1:0] s2_ff, sq2_ff, om2_ff;
   logic signed [W-1:0] s3_ff, num3_ff, den3_ff;
   logic                zero3_ff;
   logic signed [W-1:0] s4_ff, a4_ff, b4_ff;
   logic signed [W-1:0] rest5_ff, right5_ff, left5_ff;

   logic                vld_c  [NCELL+1];
   logic [W-1:0]        rem_c  [NCELL+1];
   logic [W-1:0]        den_c  [NCELL+1];
   logic [W-1:0]        quo_c  [NCELL+1];
   logic signed [W-1:0] sval_c [NCELL+1];
   logic                zero_c [NCELL+1];

   logic [W-1:0]        flux;
   logic signed [W-1:0] tval;

   assign vld_c[0]  = vld3_ff;
   assign rem_c[0]  = num3_ff;
   assign den_c[0]  = den3_ff;
   assign quo_c[0]  = '0;
   assign sval_c[0] = s3_ff;
   assign zero_c[0] = zero3_ff;

   for (genvar k = 0; k < NCELL; k++) begin : g_div
      lbf_div_cell #(.W(W)) u_cell (
         .clock   (clock),
         .reset   (reset),
         .vld_in  (vld_c[k]),
         .rem_in  (rem_c[k]),
         .den_in  (den_c[k]),
         .quo_in  (quo_c[k]),
         .sval_in (sval_c[k]),
         .zero_in (zero_c[k]),
         .vld_out (vld_c[k+1]),
         .rem_out (rem_c[k+1]),
         .den_out (den_c[k+1]),
         .quo_out (quo_c[k+1]),
         .sval_out(sval_c[k+1]),
         .zero_out(zero_c[k+1])
      );
   end

   always_comb begin
      flux = zero_c[NCELL] ? '0 : (quo_c[NCELL] >> speed_shift);
      tval = sat_e(signed'((W+2)'(flux) * (W+2)'(3)));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
         vld3_ff <= 1'b0;
         vld4_ff <= 1'b0;
         vld5_ff <= 1'b0;
      end else begin
         vld1_ff <= in_vld;
         vld2_ff <= vld1_ff;
         vld3_ff <= vld2_ff;
         vld4_ff <= vld_c[NCELL];
         vld5_ff <= vld4_ff;
      end
      s1_ff     <= in_sat;
      sq1_ff    <= mul_q(in_sat, in_sat);
      om1_ff    <= sat_e(ONE_E - (W+2)'(in_sat));
      s2_ff     <= s1_ff;
      sq2_ff    <= sq1_ff;
      om2_ff    <= mul_q(om1_ff, om1_ff);
      s3_ff     <= s2_ff;
      num3_ff   <= sq2_ff;
      den3_ff   <= sat_e((W+2)'(sq2_ff) + (W+2)'(om2_ff));
      zero3_ff  <= (sq2_ff == '0) && (om2_ff == '0);
      s4_ff     <= sval_c[NCELL];
      a4_ff     <= sat_e((W+2)'(sval_c[NCELL]) + (W+2)'(tval));
      b4_ff     <= sat_e((W+2)'(sval_c[NCELL]) - (W+2)'(tval));
      rest5_ff  <= mul_q(W_REST, s4_ff);
      right5_ff <= mul_q(W_MOVE, a4_ff);
      left5_ff  <= mul_q(W_MOVE, b4_ff);
   end

   assign out_vld   = vld5_ff;
   assign out_rest  = rest5_ff;
   assign out_right = right5_ff;
   assign out_left  = left5_ff;

endmodule

### rtl/core/lattice_boltzmann_d1q3_fractional_flow.sv
// ----------------------------------------------------------------------------
// lattice_boltzmann_d1q3_fractional_flow: D1Q3 lattice advection engine
// Keeps the per-cell saturation, advances it one time step or reads a cell.
// ----------------------------------------------------------------------------
//  channel | direction | beat contents
//  req     | in        | tuser = func, tdata = cell_req (8 bits)
//  rsp     | out       | tdata = saturation (VALUE_BITS, zero padded)
//  csr     | in        | csr_addr 0 active_cells, 1 speed_shift
//
// In a step beat the saturation RAM is read one cell per cycle into the
// collision pipeline, whose length is set by the row of division cells
// (one quotient bit each). A read beat captures the registered RAM read
// data in ST_READ and returns it as the response.
// After reset a clearing pass writes zero to all MAX_CELLS entries, one per
// cycle, and no request is taken until it ends.
// A result waiting on rsp holds off the next request until it is taken.
// ----------------------------------------------------------------------------
module lattice_boltzmann_d1q3_fractional_flow
   import lbf_pkg::*;
#(
   parameter int MAX_CELLS  = 256,
   parameter int VALUE_BITS = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [CELL_BITS-1:0]                  req_tdata,  // cell_req
   input  logic                                  req_tuser,  // func
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [((VALUE_BITS+7)/8)*8-1:0]       rsp_tdata,  // saturation
   input  logic                                  csr_we,
   input  logic [CSR_ADDR_BITS-1:0]              csr_addr,
   input  logic [CSR_DATA_BITS-1:0]              csr_wdata
);

   localparam int W  = VALUE_BITS;
   localparam int F  = W - 2;
   localparam int RB = ((W + 7) / 8) * 8;
   localparam int AW = $clog2(MAX_CELLS);
   localparam int CW = ($clog2(MAX_CELLS + 1) > ACTIVE_BITS) ?
                       $clog2(MAX_CELLS + 1) : ACTIVE_BITS;
   localparam logic [CW-1:0] MAX_N = CW'(MAX_CELLS);
   localparam logic [CW-1:0] MIN_N = CW'(3);
   localparam logic signed [W+1:0] ONE_E = (W+2)'(1) << F;
   localparam logic signed [W+1:0] MAX_E = {3'b000, {(W-1){1'b1}}};
   localparam logic signed [W+1:0] MIN_E = {3'b111, {(W-1){1'b0}}};

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_ISSUE = 3'd2;
   localparam logic [2:0] ST_DRAIN = 3'd3;
   localparam logic [2:0] ST_READ  = 3'd4;

   function automatic logic signed [W-1:0] sat_e(input logic signed [W+1:0] x);
      logic signed [W+1:0] y;
      y = x;
      if (x > MAX_E) y = MAX_E;
      if (x < MIN_E) y = MIN_E;
      return y[W-1:0];
   endfunction

   logic [2:0]             state_ff, state_in;
   logic [ACTIVE_BITS-1:0] active_ff;
   logic [SHIFT_BITS-1:0]  shift_ff;
   logic [AW-1:0]          clr_ff, rd_ff;
   logic [CW-1:0]          arr_ff, ncell, act_ext;
   logic                   tok_ff, tail_ff;
   logic signed [W-1:0]    tail_val_ff, rest_p_ff, right_p1_ff, right_p2_ff;
   logic                   rsp_vld_ff;
   logic signed [W-1:0]    rsp_dat_ff;

   logic                   req_fire, in_range;
   logic                   ram_we;
   logic [AW-1:0]          ram_waddr, ram_raddr;
   logic signed [W-1:0]    ram_wdata, ram_rdata, post_val, inner;

   logic                   c_vld;
   logic signed [W-1:0]    c_rest, c_right, c_left;

   // Effective cell count, clamped to the supported range.
   always_comb begin
      act_ext = CW'(active_ff);
      if (act_ext < MIN_N) ncell = MIN_N;
      else if (act_ext > MAX_N) ncell = MAX_N;
      else ncell = act_ext;
   end

   assign req_tready = (state_ff == ST_IDLE) && (!rsp_vld_ff || rsp_tready);
   assign req_fire   = req_tvalid && req_tready;
   assign in_range   = (CW'(req_tdata) < ncell);

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= ACTIVE_BITS'(256);
         shift_ff  <= SHIFT_BITS'(1);
      end else if (csr_we) begin
         unique case (csr_addr)
            REG_ACTIVE_CELLS: active_ff <= csr_wdata;
            REG_SPEED_SHIFT:  shift_ff  <= csr_wdata[SHIFT_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Sequencer: clearing pass, step issue and drain, single reads.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: if (clr_ff == AW'(MAX_CELLS - 1)) state_in = ST_IDLE;
         ST_IDLE: begin
            if (req_fire) begin
               if (req_tuser == FUNC_STEP) state_in = ST_ISSUE;
               else if (in_range) state_in = ST_READ;
            end
         end
         ST_ISSUE: if (CW'(rd_ff) == ncell - CW'(1)) state_in = ST_DRAIN;
         ST_DRAIN: if (tail_ff) state_in = ST_IDLE;
         ST_READ:  state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   assign ram_raddr = (state_ff == ST_ISSUE) ? rd_ff : AW'(req_tdata);

   // Sum for the cell one behind the newest arrival. The left boundary
   // forces the right-moving population so the three sum to one.
   always_comb begin
      inner = sat_e(ONE_E - (W+2)'(rest_p_ff) - (W+2)'(c_left));
      if (arr_ff == CW'(1)) begin
         post_val = sat_e((W+2)'(rest_p_ff) + (W+2)'(inner) + (W+2)'(c_left));
      end else begin
         post_val = sat_e((W+2)'(rest_p_ff) + (W+2)'(right_p2_ff) +
                          (W+2)'(c_left));
      end
   end

   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = AW'(arr_ff - CW'(1));
      ram_wdata = post_val;
      if (state_ff == ST_CLEAR) begin
         ram_we    = 1'b1;
         ram_waddr = clr_ff;
         ram_wdata = '0;
      end else if (tail_ff) begin
         // The right boundary copies its left neighbor.
         ram_we    = 1'b1;
         ram_waddr = AW'(ncell - CW'(1));
         ram_wdata = tail_val_ff;
      end else if (c_vld && (arr_ff != '0)) begin
         ram_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         clr_ff     <= '0;
         rd_ff      <= '0;
         arr_ff     <= '0;
         tok_ff     <= 1'b0;
         tail_ff    <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         tok_ff   <= (state_ff == ST_ISSUE);
         if (state_ff == ST_CLEAR) clr_ff <= clr_ff + AW'(1);
         if (state_ff == ST_ISSUE) rd_ff <= rd_ff + AW'(1);
         else rd_ff <= '0;
         if (state_ff == ST_IDLE) arr_ff <= '0;
         else if (c_vld) arr_ff <= arr_ff + CW'(1);
         tail_ff <= c_vld && (arr_ff == ncell - CW'(1));
         if (rsp_vld_ff && rsp_tready) rsp_vld_ff <= 1'b0;
         if ((state_ff == ST_IDLE && req_fire && req_tuser == FUNC_READ &&
              !in_range) || state_ff == ST_READ ||
             (state_ff == ST_DRAIN && tail_ff)) begin
            rsp_vld_ff <= 1'b1;
         end
      end
      if (c_vld) begin
         rest_p_ff   <= c_rest;
         right_p1_ff <= c_right;
         right_p2_ff <= right_p1_ff;
      end
      if (c_vld && (arr_ff == ncell - CW'(1))) tail_val_ff <= post_val;
      if (state_ff == ST_READ) rsp_dat_ff <= ram_rdata;
      else if (req_fire || (state_ff == ST_DRAIN && tail_ff)) rsp_dat_ff <= '0;
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = RB'(unsigned'(rsp_dat_ff));

   lbf_ram #(.WIDTH(W), .DEPTH(MAX_CELLS)) u_sat_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   lbf_collide #(.W(W)) u_collide (
      .clock      (clock),
      .reset      (reset),
      .speed_shift(shift_ff),
      .in_vld     (tok_ff),
      .in_sat     (ram_rdata),
      .out_vld    (c_vld),
      .out_rest   (c_rest),
      .out_right  (c_right),
      .out_left   (c_left)
   );

`ifndef SYNTH
   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !req_tready)
      else $error("request taken during clearing pass");
   a_tail_in_drain: assert property (@(posedge clock) disable iff (reset)
      tail_ff |-> (state_ff == ST_DRAIN))
      else $error("boundary copy outside of a step");
   a_read_responds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |=> rsp_tvalid)
      else $error("read produced no response");
`endif

endmodule

### sim/lattice_boltzmann_d1q3_fractional_flow_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lattice_boltzmann_d1q3_fractional_flow_test: self-checking lattice bench
// Drives step and read beats through the request stream, keeps its own
// fixed-point copy of the D1Q3 lattice and compares every response beat.
// ----------------------------------------------------------------------------
module lattice_boltzmann_d1q3_fractional_flow_test
   import lbf_pkg::*;
();

   localparam int NCELL = 256;
   localparam longint ONE_Q = 64'sd1 << 30;
   localparam longint MAX_Q = 64'sd2147483647;
   localparam longint MIN_Q = -64'sd2147483648;
   localparam longint W_REST = (4 * ONE_Q + 3) / 6;
   localparam longint W_MOVE = (ONE_Q + 3) / 6;
   localparam int LIMIT = 3000000;

   typedef struct packed {
      logic       func;
      logic [7:0] cell_idx;
   } req_beat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [7:0] req_tdata = '0;   // cell_req
   logic req_tuser = 1'b0;       // func
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;       // saturation
   logic csr_we = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_addr = '0;
   logic [CSR_DATA_BITS-1:0] csr_wdata = '0;

   lattice_boltzmann_d1q3_fractional_flow dut (.*);

   always #10 clock = ~clock;

   // Lattice mirror: three distributions and a saturation per cell.
   longint rest_q[NCELL], right_q[NCELL], left_q[NCELL], sat_q[NCELL];
   int unsigned cells_reg = 256, shift_reg = 1;

   req_beat_type pending_reqs[$];
   logic [31:0] expected_sat[$];
   int  failures = 0;
   bit  idle_off = 1'b0;
   bit  req_acc = 1'b0;
   int  cycle_count = 0;

   function automatic longint clamp_q(longint x);
      if (x > MAX_Q) return MAX_Q;
      if (x < MIN_Q) return MIN_Q;
      return x;
   endfunction

   // Exact product, truncated toward zero; operands fit 32 bits so 64 is enough.
   function automatic longint qmul(longint a, longint b);
      longint p;
      p = a * b;
      if (p < 0) return clamp_q(-((-p) >>> 30));
      return clamp_q(p >>> 30);
   endfunction

   function automatic longint qdiv(longint n, longint d);
      logic [95:0] q;
      q = ({32'd0, n[63:0]} << 30) / {32'd0, d[63:0]};
      if (q > MAX_Q) return MAX_Q;
      return longint'(q);
   endfunction

   function automatic int unsigned lattice_size();
      if (cells_reg < 3) return 3;
      if (cells_reg > NCELL) return NCELL;
      return cells_reg;
   endfunction

   // One collide-and-stream time step of the mirrored lattice.
   function automatic void advance_lattice();
      longint pr[NCELL], pm[NCELL], pl[NCELL];
      longint s, s2, om, d, flux, t;
      int unsigned n;
      n = lattice_size();
      for (int i = 0; i < n; i++) begin
         s = sat_q[i];
         s2 = qmul(s, s);
         om = clamp_q(ONE_Q - s);
         d = clamp_q(s2 + qmul(om, om));
         flux = 0;
         if (d > 0) flux = qdiv(s2, d) >>> shift_reg;
         t = clamp_q(3 * flux);
         pr[i] = qmul(W_REST, s);
         pm[i] = qmul(W_MOVE, clamp_q(s + t));
         pl[i] = qmul(W_MOVE, clamp_q(s - t));
      end
      for (int i = 0; i < n; i++) begin
         rest_q[i] = pr[i];
         right_q[i] = pm[i == 0 ? n - 1 : i - 1];
         left_q[i] = pl[i == n - 1 ? 0 : i + 1];
      end
      // Inlet held at saturation one, outlet copies its neighbor.
      right_q[0] = clamp_q(ONE_Q - rest_q[0] - left_q[0]);
      rest_q[n-1] = rest_q[n-2];
      right_q[n-1] = right_q[n-2];
      left_q[n-1] = left_q[n-2];
      for (int i = 0; i < n; i++)
         sat_q[i] = clamp_q(rest_q[i] + right_q[i] + left_q[i]);
   endfunction

   function automatic logic [31:0] predict_saturation(req_beat_type b);
      if (b.func == FUNC_STEP) begin
         advance_lattice();
         return '0;
      end
      if (b.cell_idx < lattice_size()) return sat_q[b.cell_idx][31:0];
      return '0;
   endfunction

   // Request handshake as seen at the rising edge.
   always @(posedge clock) begin
      req_acc = !reset && req_tvalid && req_tready;
   end

   // Driver: one beat at a time from the pending queue, random gaps between.
   int gap_left = 0;
   always @(negedge clock) begin
      if (!reset) begin
         if (req_acc) begin
            expected_sat.push_back(predict_saturation(pending_reqs.pop_front()));
            if (!idle_off && $urandom_range(0, 3) == 0) gap_left = $urandom_range(1, 8);
         end
         if (req_tvalid && !req_acc) begin
            // hold the beat
         end else if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (pending_reqs.size() > 0) begin
            req_tvalid <= 1'b1;
            req_tuser <= pending_reqs[0].func;
            req_tdata <= pending_reqs[0].cell_idx;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Response sink with bursts of back-pressure.
   int stall_left = 0;
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (!idle_off && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(0, 7);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !reset;
      end
   end

   // Monitor: sampled at the rising edge, compared against the oldest entry.
   always @(posedge clock) begin
      cycle_count++;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_sat.size() == 0) begin
            $error("saturation: unexpected beat, actual %h", rsp_tdata);
            failures++;
         end else begin
            logic [31:0] want;
            want = expected_sat.pop_front();
            if (rsp_tdata !== want) begin
               $error("saturation: expected %h actual %h", want, rsp_tdata);
               failures++;
            end
         end
      end
      if (cycle_count > LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   task automatic write_reg(logic [CSR_ADDR_BITS-1:0] idx, int unsigned value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= value[CSR_DATA_BITS-1:0];
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == REG_ACTIVE_CELLS) cells_reg = value & 9'h1FF;
      else shift_reg = value & 4'hF;
   endtask

   // Wait until everything queued has been taken and answered.
   task automatic drain();
      while (pending_reqs.size() > 0 || expected_sat.size() > 0 || req_tvalid)
         @(negedge clock);
      repeat (300) @(negedge clock);
   endtask

   task automatic queue_req(logic f, logic [7:0] c);
      req_beat_type b;
      b.func = f;
      b.cell_idx = c;
      pending_reqs.push_back(b);
   endtask

   // A phase: a few steps, each followed by reads spread over the lattice.
   task automatic run_phase(int steps);
      for (int k = 0; k < steps; k++) begin
         queue_req(FUNC_STEP, 8'($urandom));
         repeat ($urandom_range(1, 6))
            queue_req(FUNC_READ, $urandom_range(0, 3) == 0 ? 8'($urandom)
                      : 8'($urandom_range(0, lattice_size() - 1)));
      end
      drain();
   endtask

   initial begin
      for (int i = 0; i < NCELL; i++) begin
         rest_q[i] = 0; right_q[i] = 0; left_q[i] = 0; sat_q[i] = 0;
      end
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: reads of the cleared lattice, edges, then small lattices.
      queue_req(FUNC_READ, 8'd0);
      queue_req(FUNC_READ, 8'd255);
      queue_req(FUNC_STEP, 8'd0);
      queue_req(FUNC_READ, 8'd0);
      queue_req(FUNC_READ, 8'd1);
      queue_req(FUNC_READ, 8'd255);
      drain();
      write_reg(REG_ACTIVE_CELLS, 0);    // below the floor: three cells
      write_reg(REG_SPEED_SHIFT, 0);
      for (int k = 0; k < 4; k++) begin
         queue_req(FUNC_STEP, 8'hFF);
         queue_req(FUNC_READ, 8'd0);
         queue_req(FUNC_READ, 8'd2);
         queue_req(FUNC_READ, 8'd3);     // past the count
      end
      drain();
      write_reg(REG_ACTIVE_CELLS, 511);  // above the ceiling: all cells
      write_reg(REG_SPEED_SHIFT, 15);
      run_phase(3);

      // Random phases over many settings, mostly small lattices.
      for (int p = 0; p < 14; p++) begin
         write_reg(REG_ACTIVE_CELLS,
                   p % 5 == 4 ? $urandom_range(0, 511) : $urandom_range(3, 24));
         write_reg(REG_SPEED_SHIFT, $urandom_range(0, 15));
         run_phase($urandom_range(4, 10));
      end
      write_reg(REG_ACTIVE_CELLS, 3);
      write_reg(REG_SPEED_SHIFT, 0);
      run_phase(6);

      // Last stretch without any idling.
      idle_off = 1'b1;
      write_reg(REG_ACTIVE_CELLS, 16);
      write_reg(REG_SPEED_SHIFT, 2);
      run_phase(10);

      if (failures == 0 && expected_sat.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
